>>> rtl/ffha_pkg.sv
// Shared types, constants and codes for the first-fit heap allocator.
// No dependencies; ffha_round and the top level refer to it by scoped names.
package ffha_pkg;

  // Field widths
  localparam int ADDR_W = 21;
  localparam int NEED_W = 22;

  // Default geometry
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int DEF_ALIGN_BYTES  = 8;

  // Heap size register limits and reset value
  localparam logic [ADDR_W-1:0] HEAP_MIN   = 21'd64;
  localparam logic [ADDR_W-1:0] HEAP_MAX   = 21'd1048576;
  localparam logic [ADDR_W-1:0] HEAP_RESET = 21'd65536;

  // Request kinds
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_REALLOC = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_BADADR = 2'd2;

  // One segment table entry
  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] size;
    logic              free;
  } entry_t;

  // Result of the rounding unit
  typedef struct packed {
    logic              done;
    logic [NEED_W-1:0] need;
  } rnd_res_t;

endpackage

>>> rtl/ffha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ffha_round.sv
// Round-up of a request size to the alignment, result registered in the cycle after start.
// ALIGN_BYTES is a power of two, so the round-up is an add and a mask. Depends on ffha_pkg.
module ffha_round #(
  parameter int ALIGN_BYTES = ffha_pkg::DEF_ALIGN_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ffha_pkg::ADDR_W-1:0]   req,
  output ffha_pkg::rnd_res_t            res
);

  localparam int NW = ffha_pkg::NEED_W;
  localparam logic [NW-1:0] LOW_MASK = NW'(ALIGN_BYTES - 1);

  logic [NW-1:0]                sum;
  logic [NW-1:0]                need_r;
  logic                         done_r;

  // Add alignment minus one, then clear the low bits
  assign sum = {1'b0, req} + LOW_MASK;

  // Capture on start, pulse done the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
      if (start) begin
        need_r <= sum & ~LOW_MASK;
      end
    end
  end

  assign res.done = done_r;
  assign res.need = need_r;

endmodule

>>> rtl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator with coalescing over a segment table RAM.
// Depends on ffha_pkg, ffha_ram and ffha_round.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | req_type, request_size, payload_address
//  out_    | output    | out_valid/out_stall| status, result_address, copy_length
//  cfg_    | input     | cfg_valid/cfg_ready| heap_bytes write data
//
// A request takes a size rounding step, then a read and a check step per table entry
// walked by each search, plus a read and a write step per entry moved by a split or a
// merge, the split writes, the neighbor reads and merge write-back, and an output step;
// the one-write, one-read segment RAM read/modify/write sequence sets these steps.
// Reset and every heap size write rewrite entry 0 in the S_INIT step.
// A finished result waits in the output register; the next beat is taken meanwhile.
module first_fit_heap_allocator #(
  parameter int MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
  parameter int ALIGN_BYTES  = ffha_pkg::DEF_ALIGN_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [ffha_pkg::ADDR_W-1:0] in_request_size,
  input  logic [ffha_pkg::ADDR_W-1:0] in_payload_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [ffha_pkg::ADDR_W-1:0] out_result_address,
  output logic [ffha_pkg::ADDR_W-1:0] out_copy_length,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffha_pkg::ADDR_W-1:0] cfg_data
);

  localparam int AW = ffha_pkg::ADDR_W;
  localparam int NW = ffha_pkg::NEED_W;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int EW = $bits(ffha_pkg::entry_t);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RND, F_RD, F_CHK, A_RD, A_CHK, SH_RD, SH_WR,
    SP_W1, SP_W2, A_DONE, M_RDP, M_RDN, M_CAP, M_WB, MS_RD, MS_WR, S_OUT
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        heap_r;
  logic [1:0]           kind_r;
  logic [AW-1:0]        req_r, addr_r;
  logic [NW-1:0]        need_r;
  logic [CW-1:0]        cnt_r, idx_r, ai_r, fi_r, base_r, j_r;
  logic [1:0]           k_r;
  logic [AW-1:0]        ho_r, hs_r, fo_r, fs_r, po_r, ps_r, ns_r;
  logic                 split_r, pf_r, nf_r;
  logic [1:0]           st_r;
  logic [AW-1:0]        res_r, copy_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [AW-1:0]        out_res_r, out_copy_r;

  ffha_pkg::entry_t     rd, wdata;
  logic [EW-1:0]        rdata_raw;
  logic                 we;
  logic [CW-1:0]        waddr_full, raddr_full;
  logic                 in_acc, cfg_acc;
  logic [AW-1:0]        cfg_clamped;
  ffha_pkg::rnd_res_t   rnd;
  logic                 hit, split_ok, match;
  logic                 m_pf;
  logic [CW-1:0]        m_base;
  logic [NW-1:0]        m_size;
  logic [1:0]           m_k;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign rd        = ffha_pkg::entry_t'(rdata_raw);

  assign cfg_clamped = (cfg_data < ffha_pkg::HEAP_MIN) ? ffha_pkg::HEAP_MIN :
                       (cfg_data > ffha_pkg::HEAP_MAX) ? ffha_pkg::HEAP_MAX : cfg_data;

  // Entry tests on the read data
  assign hit      = rd.free && ({1'b0, rd.size} >= need_r);
  assign split_ok = ((NW+1)'(rd.size) >= (NW+1)'(need_r) + (NW+1)'(HEADER_BYTES)
                     + (NW+1)'(ALIGN_BYTES)) && (cnt_r < CW'(MAX_SEGMENTS));
  assign match    = !rd.free && ((NW'(rd.off) + NW'(HEADER_BYTES)) == {1'b0, addr_r});

  // Merge arithmetic around the freed entry
  assign m_pf   = pf_r;
  assign m_base = m_pf ? fi_r - 1'b1 : fi_r;
  assign m_size = NW'(fs_r) + (m_pf ? NW'(ps_r) + NW'(HEADER_BYTES) : '0)
                + (nf_r ? NW'(ns_r) + NW'(HEADER_BYTES) : '0);
  assign m_k    = {1'b0, pf_r} + {1'b0, nf_r};

  // Drive RAM ports per sequencer step
  always_comb begin
    we         = 1'b0;
    waddr_full = '0;
    wdata      = '0;
    raddr_full = '0;
    unique case (state_r)
      S_INIT: begin
        we         = 1'b1;
        wdata.off  = '0;
        wdata.size = (heap_r > AW'(HEADER_BYTES)) ? heap_r - AW'(HEADER_BYTES) : '0;
        wdata.free = 1'b1;
      end
      F_RD, A_RD: raddr_full = idx_r;
      A_CHK: begin
        if (hit && !split_ok) begin
          we         = 1'b1;
          waddr_full = idx_r;
          wdata      = rd;
          wdata.free = 1'b0;
        end
      end
      SH_RD: raddr_full = j_r;
      SH_WR: begin
        we         = 1'b1;
        waddr_full = j_r + 1'b1;
        wdata      = rd;
      end
      SP_W1: begin
        we         = 1'b1;
        waddr_full = ai_r;
        wdata.off  = ho_r;
        wdata.size = need_r[AW-1:0];
        wdata.free = 1'b0;
      end
      SP_W2: begin
        we         = 1'b1;
        waddr_full = ai_r + 1'b1;
        wdata.off  = AW'(NW'(ho_r) + NW'(HEADER_BYTES) + need_r);
        wdata.size = AW'(NW'(hs_r) - need_r - NW'(HEADER_BYTES));
        wdata.free = 1'b1;
      end
      M_RDP: raddr_full = fi_r - 1'b1;
      M_RDN: raddr_full = fi_r + 1'b1;
      M_WB: begin
        we         = 1'b1;
        waddr_full = m_base;
        wdata.off  = m_pf ? po_r : fo_r;
        wdata.size = m_size[AW-1:0];
        wdata.free = 1'b1;
      end
      MS_RD: raddr_full = j_r + CW'(k_r);
      MS_WR: begin
        we         = 1'b1;
        waddr_full = j_r;
        wdata      = rd;
      end
      default: ;
    endcase
  end

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_full[IW-1:0]),
    .wdata (wdata),
    .raddr (raddr_full[IW-1:0]),
    .rdata (rdata_raw)
  );

  ffha_round #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .req   (in_request_size),
    .res   (rnd)
  );

  // Sequencer, table count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      heap_r      <= ffha_pkg::HEAP_RESET;
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          cnt_r   <= CW'(1);
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_acc) begin
            heap_r  <= cfg_clamped;
            state_r <= S_INIT;
          end else if (in_acc) begin
            kind_r  <= in_req_type;
            req_r   <= in_request_size;
            addr_r  <= in_payload_address;
            st_r    <= ffha_pkg::ST_OK;
            res_r   <= '0;
            copy_r  <= '0;
            idx_r   <= '0;
            state_r <= S_RND;
          end
        end
        // dispatch once the rounded size is known
        S_RND: begin
          if (rnd.done) begin
            need_r <= rnd.need;
            case (kind_r)
              ffha_pkg::REQ_ALLOC: state_r <= A_RD;
              ffha_pkg::REQ_FREE:  state_r <= (addr_r == '0) ? S_OUT : F_RD;
              ffha_pkg::REQ_REALLOC: state_r <= (addr_r == '0) ? A_RD : F_RD;
              default: state_r <= S_OUT;
            endcase
          end
        end
        F_RD: begin
          if (idx_r == cnt_r) begin
            st_r    <= ffha_pkg::ST_BADADR;
            state_r <= S_OUT;
          end else begin
            state_r <= F_CHK;
          end
        end
        F_CHK: begin
          if (match) begin
            fi_r <= idx_r;
            fo_r <= rd.off;
            fs_r <= rd.size;
            if (kind_r == ffha_pkg::REQ_FREE) begin
              state_r <= M_RDP;
            end else if (rd.size >= req_r) begin
              res_r   <= addr_r;
              state_r <= S_OUT;
            end else begin
              idx_r   <= '0;
              state_r <= A_RD;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= F_RD;
          end
        end
        A_RD: begin
          if (idx_r == cnt_r) begin
            st_r    <= ffha_pkg::ST_NOFIT;
            state_r <= S_OUT;
          end else begin
            state_r <= A_CHK;
          end
        end
        A_CHK: begin
          if (hit) begin
            ho_r    <= rd.off;
            hs_r    <= rd.size;
            ai_r    <= idx_r;
            split_r <= split_ok;
            j_r     <= cnt_r - 1'b1;
            state_r <= split_ok ? SH_RD : A_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= A_RD;
          end
        end
        // open a slot after the hit entry
        SH_RD: state_r <= (j_r <= ai_r) ? SP_W1 : SH_WR;
        SH_WR: begin
          j_r     <= j_r - 1'b1;
          state_r <= SH_RD;
        end
        SP_W1: state_r <= SP_W2;
        SP_W2: begin
          cnt_r   <= cnt_r + 1'b1;
          state_r <= A_DONE;
        end
        A_DONE: begin
          res_r <= AW'(ho_r + AW'(HEADER_BYTES));
          if (kind_r == ffha_pkg::REQ_REALLOC && addr_r != '0) begin
            copy_r  <= fs_r;
            fi_r    <= (split_r && ai_r < fi_r) ? fi_r + 1'b1 : fi_r;
            state_r <= M_RDP;
          end else begin
            state_r <= S_OUT;
          end
        end
        // fetch neighbors of the freed entry
        M_RDP: state_r <= M_RDN;
        M_RDN: begin
          pf_r    <= (fi_r != '0) && rd.free;
          po_r    <= rd.off;
          ps_r    <= rd.size;
          state_r <= M_CAP;
        end
        M_CAP: begin
          nf_r    <= ((fi_r + 1'b1) < cnt_r) && rd.free;
          ns_r    <= rd.size;
          state_r <= M_WB;
        end
        M_WB: begin
          base_r  <= m_base;
          k_r     <= m_k;
          j_r     <= m_base + 1'b1;
          state_r <= (m_k == '0) ? S_OUT : MS_RD;
        end
        // close the gap left by merged entries
        MS_RD: begin
          if ((j_r + CW'(k_r)) >= cnt_r) begin
            cnt_r   <= cnt_r - CW'(k_r);
            state_r <= S_OUT;
          end else begin
            state_r <= MS_WR;
          end
        end
        MS_WR: begin
          j_r     <= j_r + 1'b1;
          state_r <= MS_RD;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_res_r    <= res_r;
            out_copy_r   <= copy_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_res_r;
  assign out_copy_length    = out_copy_r;

  // Table count stays within its bounds
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CW'(1)) && (cnt_r <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  // A result appears only from the output step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output step");

  // A failed or flagged request returns no address
  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ffha_pkg::ST_OK) |-> (out_res_r == '0))
    else $error("failed request returned an address");

  // Rounding finishes only while the sequencer waits for it
  a_rnd_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rnd.done |-> (state_r == S_RND))
    else $error("rounding result with no waiting request");

  // A base-entry rewrite merges at most two neighbors
  a_merge_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MS_RD) |-> (k_r != 2'd0) && (k_r <= 2'd2) && (base_r < cnt_r))
    else $error("bad merge count");

endmodule
